/* rtl/sba_pkg.sv */
// ============================================================================
// sba_pkg
// Shared types and constants for the bump and free stack slot allocator.
// ============================================================================
`default_nettype none

package sba_pkg;

    // Geometry
    localparam int MAX_SLOTS   = 256;
    localparam int SLOT_STRIDE = 32;
    localparam int ADDR_W      = 32;
    localparam int DEPTH_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W       = $clog2(MAX_SLOTS + 1);

    // Base address alignment: low four bits read as zero
    localparam logic [ADDR_W-1:0] ALIGN_MASK = 32'hFFFF_FFF0;

    // Operation codes
    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // Register indexes
    localparam logic [0:0] REG_BASE = 1'b0;
    localparam logic [0:0] REG_MODE = 1'b1;

    // Allocator counters
    typedef struct packed {
        logic [CNT_W-1:0] free_depth;
        logic [CNT_W-1:0] bump;
        logic [CNT_W-1:0] live;
        logic [CNT_W-1:0] peak;
    } sba_state_t;

    // One result item
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [1:0]        status;
        logic [CNT_W-1:0]  live;
        logic [CNT_W-1:0]  peak;
    } sba_result_t;

    // Stack write request
    typedef struct packed {
        logic               en;
        logic [DEPTH_W-1:0] addr;
        logic [ADDR_W-1:0]  data;
    } sba_push_t;

endpackage

`default_nettype wire

/* rtl/sba_ram.sv */
// ============================================================================
// sba_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module sba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/sba_step.sv */
// ============================================================================
// sba_step
// Next-state and result logic for one acquire or release item.
// ============================================================================
`default_nettype none

module sba_step (
    input  wire logic                      operation,
    input  wire logic [sba_pkg::ADDR_W-1:0] release_address,
    input  wire logic [sba_pkg::ADDR_W-1:0] base_address,
    input  wire logic                      no_reuse_mode,
    input  wire logic [sba_pkg::ADDR_W-1:0] top_data,
    input  wire sba_pkg::sba_state_t       cur,
    output sba_pkg::sba_state_t            nxt,
    output sba_pkg::sba_result_t           res,
    output sba_pkg::sba_push_t             push
);

    logic                           bump_ok;
    logic [sba_pkg::CNT_W-1:0]      bump_inc;
    logic [sba_pkg::CNT_W-1:0]      live_inc;
    logic [sba_pkg::ADDR_W-1:0]     fresh_addr;

    // Fresh slot address, wraps at 32 bits
    assign fresh_addr = base_address
                      + sba_pkg::ADDR_W'(cur.bump) * sba_pkg::ADDR_W'(sba_pkg::SLOT_STRIDE);
    assign bump_ok    = cur.bump < sba_pkg::CNT_W'(sba_pkg::MAX_SLOTS);
    assign bump_inc   = cur.bump + 1'b1;
    assign live_inc   = cur.live + 1'b1;

    always_comb
    begin
        nxt        = cur;
        res.addr   = '0;
        res.status = sba_pkg::ST_OK;
        push.en    = 1'b0;
        push.addr  = cur.free_depth[sba_pkg::DEPTH_W-1:0];
        push.data  = release_address;

        if (operation == sba_pkg::OP_ACQUIRE)
        begin
            if (no_reuse_mode)
            begin
                // bump only, peak follows bump count
                if (bump_ok)
                begin
                    res.addr = fresh_addr;
                    nxt.bump = bump_inc;
                    if (bump_inc > cur.peak)
                    begin
                        nxt.peak = bump_inc;
                    end
                end
                else
                begin
                    res.status = sba_pkg::ST_EXHAUSTED;
                end
            end
            else if (cur.free_depth != '0)
            begin
                // reuse most recently released slot
                nxt.free_depth = cur.free_depth - 1'b1;
                res.addr       = top_data;
                nxt.live       = live_inc;
            end
            else if (bump_ok)
            begin
                res.addr = fresh_addr;
                nxt.bump = bump_inc;
                nxt.live = live_inc;
                if (live_inc > cur.peak)
                begin
                    nxt.peak = live_inc;
                end
            end
            else
            begin
                res.status = sba_pkg::ST_EXHAUSTED;
            end
        end
        else if (!no_reuse_mode)
        begin
            if (cur.live == '0)
            begin
                res.status = sba_pkg::ST_UNDERFLOW;
            end
            else
            begin
                nxt.live = cur.live - 1'b1;
                // full stack drops the push
                if (cur.free_depth < sba_pkg::CNT_W'(sba_pkg::MAX_SLOTS))
                begin
                    push.en        = 1'b1;
                    nxt.free_depth = cur.free_depth + 1'b1;
                end
            end
        end

        res.live = nxt.live;
        res.peak = nxt.peak;
    end

endmodule

`default_nettype wire

/* rtl/bump_and_free_stack_slot_allocator.sv */
// ============================================================================
// bump_and_free_stack_slot_allocator
// Slot allocator: LIFO free stack in RAM with a bump counter fallback.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall): operation and release_address.
//   One result item per input item on the output channel (out_valid /
//   out_stall): slot_address, status, live_count, peak_count.
//   Config channel (cfg_valid / cfg_ready): index 0 base_address, index 1
//   no_reuse_mode. cfg_ready is always high; write only while idle.
// Timing:
//   An accepted item reads the stack top from the free stack RAM in the
//   accept cycle; the next cycle updates state and loads the output
//   register and raises out_valid. The RAM read-modify-write means no new
//   item is taken while an accepted item is still pending.
// Reset:
//   rst_n clears counters, config registers and valid flags. The free stack RAM
//   needs no clearing; an entry is only popped after it was pushed.
// Stall:
//   While out_stall holds a result, the output register keeps its payload
//   and in_stall rises, so no item is lost.
// ============================================================================
`default_nettype none

module bump_and_free_stack_slot_allocator (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // input channel
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       operation,
    input  wire logic [sba_pkg::ADDR_W-1:0] release_address,
    // output channel
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic      [sba_pkg::ADDR_W-1:0] slot_address,
    output logic      [1:0]                 status,
    output logic      [sba_pkg::CNT_W-1:0]  live_count,
    output logic      [sba_pkg::CNT_W-1:0]  peak_count,
    // config channel
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [0:0]                 cfg_index,
    input  wire logic [sba_pkg::ADDR_W-1:0] cfg_data
);

    logic [sba_pkg::ADDR_W-1:0]  base_reg;
    logic                        mode_reg;
    sba_pkg::sba_state_t         state_reg;
    sba_pkg::sba_state_t         state_next;
    logic                        pend_reg;
    logic                        op_reg;
    logic [sba_pkg::ADDR_W-1:0]  rel_reg;
    logic                        out_valid_reg;
    sba_pkg::sba_result_t        out_reg;
    sba_pkg::sba_result_t        res;
    sba_pkg::sba_push_t          push;
    logic [sba_pkg::ADDR_W-1:0]  top_data;
    logic [sba_pkg::DEPTH_W-1:0] top_addr;
    logic                        in_accept;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign in_stall  = pend_reg | (out_valid_reg & out_stall);
    assign in_accept = in_valid & ~in_stall;
    assign top_addr  = state_reg.free_depth[sba_pkg::DEPTH_W-1:0] - 1'b1;

    // Free stack storage
    sba_ram #(
        .WIDTH (sba_pkg::ADDR_W),
        .DEPTH (sba_pkg::MAX_SLOTS)
    ) u_stack (
        .clk     (clk),
        .wr_en   (pend_reg & push.en),
        .wr_addr (push.addr),
        .wr_data (push.data),
        .rd_en   (in_accept),
        .rd_addr (top_addr),
        .rd_data (top_data)
    );

    // Item evaluation
    sba_step u_step (
        .operation       (op_reg),
        .release_address (rel_reg),
        .base_address    (base_reg),
        .no_reuse_mode   (mode_reg),
        .top_data        (top_data),
        .cur             (state_reg),
        .nxt             (state_next),
        .res             (res),
        .push            (push)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sba_pkg::REG_BASE: base_reg <= cfg_data & sba_pkg::ALIGN_MASK;
                sba_pkg::REG_MODE: mode_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Counters and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= in_accept;
            if (pend_reg)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg  <= operation;
            rel_reg <= release_address;
        end
        if (pend_reg)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign slot_address = out_reg.addr;
    assign status       = out_reg.status;
    assign live_count   = out_reg.live;
    assign peak_count   = out_reg.peak;

    // Checks
    a_pend_clear_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !out_valid_reg)
        else $error("pending item with output still occupied");

    a_accept_pend: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> pend_reg)
        else $error("accepted item not evaluated");

    a_slot_budget: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, state_reg.live} + {1'b0, state_reg.free_depth})
            <= {1'b0, state_reg.bump})
        else $error("live plus free exceeds bumped slots");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.status == sba_pkg::ST_OK
                        || out_reg.status == sba_pkg::ST_EXHAUSTED
                        || out_reg.status == sba_pkg::ST_UNDERFLOW))
        else $error("invalid status code");

endmodule

`default_nettype wire
